### rtl/fit_based_block_allocator_core_defines.svh
// Assertion macros for the fit-based block allocator.
// Used by the top level; needs clk and rst in scope.
`ifndef FIT_BASED_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIT_BASED_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define FBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fba_pkg.sv
// Shared constants, codes and control structs of the block allocator.
// No dependencies.
`timescale 1ns / 1ps

package fba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int STRAT_W    = 2;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // strategy codes
  localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRATEGY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;    // write table entry from input word
    logic start;   // latch request, clear scan state
    logic step;    // examine one entry
    logic commit;  // write result register, mark block used
  } fba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;       // nothing to scan: bad strategy or zero count
    logic last;       // current entry is the last in range
    logic first_hit;  // first fit found a block at current entry
  } fba_stat_t;

endpackage

### rtl/fba_datapath.sv
// Datapath: config registers, size table, used marks, scan compare and result.
// Depends on fba_pkg.
`timescale 1ns / 1ps

module fba_datapath
  import fba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IDX_W-1:0]      block_index,
  input  logic [SIZE_BITS-1:0]  size_value,
  input  fba_cmd_t              cmd_bus,
  output fba_stat_t             stat_bus,
  output logic                  found,
  output logic [IDX_W-1:0]      granted_block
);

  logic [STRAT_W-1:0]   strategy;
  logic [COUNT_W-1:0]   block_count;
  logic [SIZE_BITS-1:0] sizes [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] used;

  logic [SIZE_BITS-1:0] req;
  logic [IDX_W-1:0]     cnt;
  logic                 pick_valid;
  logic [IDX_W-1:0]     pick_idx;
  logic [SIZE_BITS-1:0] best_left;

  logic [CNT_W-1:0]     limit;
  logic [SIZE_BITS-1:0] entry_size;
  logic [SIZE_BITS-1:0] left;
  logic                 fit;
  logic                 better;

  // count saturates at table depth
  assign limit = (block_count > COUNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                       : CNT_W'(block_count);

  assign entry_size = sizes[cnt];
  assign fit        = !used[cnt] && (entry_size >= req);
  assign left       = entry_size - req;

  always_comb begin
    better = 1'b0;
    if (fit) begin
      if (!pick_valid) begin
        better = 1'b1;
      end else if (strategy == STRAT_BEST) begin
        better = (left < best_left);
      end else if (strategy == STRAT_WORST) begin
        better = (left > best_left);
      end
    end
  end

  assign stat_bus.skip      = (strategy != STRAT_FIRST && strategy != STRAT_BEST &&
                               strategy != STRAT_WORST) || (limit == '0);
  assign stat_bus.last      = ((CNT_W'(cnt) + CNT_W'(1)) == limit);
  assign stat_bus.first_hit = (strategy == STRAT_FIRST) && fit;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy    <= STRAT_FIRST;
      block_count <= COUNT_W'(NUM_BLOCKS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRATEGY:    strategy    <= cfg_data[STRAT_W-1:0];
        REG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // size table, no reset
  always_ff @(posedge clk) begin
    if (cmd_bus.load) begin
      sizes[block_index] <= size_value;
    end
  end

  // used marks
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd_bus.load) begin
      used[block_index] <= 1'b0;
    end else if (cmd_bus.commit && pick_valid) begin
      used[pick_idx] <= 1'b1;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      pick_valid <= 1'b0;
    end else if (cmd_bus.start) begin
      pick_valid <= 1'b0;
    end else if (cmd_bus.step && better) begin
      pick_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.start) begin
      req <= size_value;
      cnt <= '0;
    end else if (cmd_bus.step) begin
      cnt <= cnt + IDX_W'(1);
      if (better) begin
        pick_idx  <= cnt;
        best_left <= left;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd_bus.commit) begin
      found         <= pick_valid;
      granted_block <= pick_valid ? pick_idx : '0;
    end
  end

endmodule

### rtl/fba_ctrl.sv
// Controller: sequences load, scan and commit; owns the handshakes.
// Depends on fba_pkg.
`timescale 1ns / 1ps

module fba_ctrl
  import fba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  input  fba_stat_t stat_bus,
  output fba_cmd_t  cmd_bus
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state;
  logic   accept;
  logic   commit_ok;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign commit_ok = (state == ST_COMMIT) && (!out_valid || out_ready);

  always_comb begin
    cmd_bus.load   = accept && (cmd == CMD_LOAD);
    cmd_bus.start  = accept && (cmd == CMD_ALLOC);
    cmd_bus.step   = (state == ST_SCAN);
    cmd_bus.commit = commit_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (commit_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && cmd == CMD_ALLOC) begin
            state <= stat_bus.skip ? ST_COMMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat_bus.first_hit || stat_bus.last) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit_ok) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/fit_based_block_allocator_core.sv
// Fit-based block allocator: top level joining controller and datapath.
// Depends on fba_pkg, fba_ctrl, fba_datapath and the assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: cmd, block_index,
//   size_value. cmd load writes size_value into table entry block_index and
//   clears its used mark; it gives no result word.
//   cmd allocate searches the first block_count entries for a free block of
//   at least size_value, by the strategy register (first, best or worst
//   fit; ties go to the lowest index), marks it used and returns one result
//   word (found, granted_block) on the output channel (out_valid/out_ready).
//   Timing: an allocate walks the table with one comparator, one entry per
//   cycle, over n = min(block_count, 16) entries, and ends early when first
//   fit hits; strategy 3 or a zero count skips the scan. The commit step then
//   writes the result word, and no new word is taken before it is done.
//   Output stall: the result register holds its word; a later load is still
//   taken, but the next allocate waits at commit until the slot is free.
//   Reset (rst, synchronous): strategy = first fit, block_count = 16, all used
//   marks clear, output empty. Table sizes are undefined until loaded. Config:
//   cfg_we/cfg_index/cfg_data; user writes only while block is idle, unchecked.
`timescale 1ns / 1ps
`include "fit_based_block_allocator_core_defines.svh"

module fit_based_block_allocator_core
  import fba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input word
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [IDX_W-1:0]      block_index,
  input  logic [SIZE_BITS-1:0]  size_value,
  // result word
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [IDX_W-1:0]      granted_block
);

  fba_cmd_t  cmd_bus;
  fba_stat_t stat_bus;

  // sequencing and handshakes
  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat_bus  (stat_bus),
    .cmd_bus   (cmd_bus)
  );

  // table, compare and result register
  fba_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .block_index   (block_index),
    .size_value    (size_value),
    .cmd_bus       (cmd_bus),
    .stat_bus      (stat_bus),
    .found         (found),
    .granted_block (granted_block)
  );

  // a miss always reports block zero
  `FBA_ASSERT_NOW(a_miss_zero, out_valid && !found, granted_block == '0, "miss with nonzero block")
  // an allocate drops in_ready in the cycle after it is accepted
  `FBA_ASSERT_NEXT(a_alloc_busy, in_valid && in_ready && cmd == CMD_ALLOC, !in_ready, "allocate not busy")
  // a load completes in its accept cycle
  `FBA_ASSERT_NEXT(a_load_quick, in_valid && in_ready && cmd == CMD_LOAD, in_ready, "load stalled input")
  // a new result only comes out of the commit step, never from idle
  `FBA_ASSERT_NOW(a_result_src, $rose(out_valid), $past(!in_ready), "result from idle")

endmodule
